### rtl/core/dpir_pkg.sv
// Shared types and constants for the palette index remap block.
package dpir_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 256;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    // RLE8 escape codes
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [1:0] {
        MODE_8BIT = 2'd0,
        MODE_4BIT = 2'd1,
        MODE_RLE8 = 2'd2,
        MODE_RLE4 = 2'd3
    } t_mode;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_DATA  = 1'b1
    } t_cmd;

    // how the back end treats a data beat
    typedef enum logic [1:0] {
        KIND_PASS   = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_NIBBLE = 2'd2
    } t_kind;

    typedef enum logic [7:0] {
        PH_COUNT   = 8'b0000_0001,
        PH_INDEX   = 8'b0000_0010,
        PH_ESC     = 8'b0000_0100,
        PH_DELTA_X = 8'b0000_1000,
        PH_DELTA_Y = 8'b0001_0000,
        PH_LITERAL = 8'b0010_0000,
        PH_PAD     = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_cmd        cmd;
        t_kind       kind;
        logic [7:0]  index;
        logic [7:0]  value;
        logic        last;
    } t_qent;

endpackage

### rtl/core/dpir_front.sv
// Front end: RLE8 parser that tags each beat with its translation kind.
module dpir_front
    import dpir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mode      i_mode,
    input  logic       i_accept,
    input  logic       i_cmd,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output t_qent      o_ent
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_remain, n_remain;
    logic       r_pad, n_pad;
    logic [7:0] dec_remain;
    t_kind      kind;

    assign dec_remain = (r_remain != 8'd0) ? (r_remain - 8'd1) : r_remain;

    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_pad    = r_pad;
        case (r_phase)
            PH_COUNT: begin
                n_phase = (i_byte_value != 8'd0) ? PH_INDEX : PH_ESC;
            end
            PH_INDEX: begin
                n_phase = PH_COUNT;
            end
            PH_ESC: begin
                if (i_byte_value == ESC_EOL) begin
                    n_phase = PH_COUNT;
                end else if (i_byte_value == ESC_EOB) begin
                    n_phase = PH_DONE;
                end else if (i_byte_value == ESC_DELTA) begin
                    n_phase = PH_DELTA_X;
                end else begin
                    n_remain = i_byte_value;
                    n_pad    = i_byte_value[0];
                    n_phase  = PH_LITERAL;
                end
            end
            PH_DELTA_X: begin
                n_phase = PH_DELTA_Y;
            end
            PH_DELTA_Y: begin
                n_phase = PH_COUNT;
            end
            PH_LITERAL: begin
                n_remain = dec_remain;
                if (dec_remain == 8'd0) begin
                    n_phase = r_pad ? PH_PAD : PH_COUNT;
                    n_pad   = 1'b0;
                end
            end
            PH_PAD: begin
                n_phase = PH_COUNT;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        case (i_mode)
            MODE_8BIT: kind = KIND_FULL;
            MODE_4BIT: kind = KIND_NIBBLE;
            MODE_RLE8: kind = (r_phase == PH_INDEX || r_phase == PH_LITERAL) ?
                              KIND_FULL : KIND_PASS;
            default:   kind = KIND_PASS;
        endcase
    end

    assign o_ent.cmd   = t_cmd'(i_cmd);
    assign o_ent.kind  = kind;
    assign o_ent.index = i_entry_index;
    assign o_ent.value = i_byte_value;
    assign o_ent.last  = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COUNT;
            r_remain <= 8'd0;
            r_pad    <= 1'b0;
        end else if (i_accept && (t_cmd'(i_cmd) == CMD_DATA)) begin
            if (i_last_byte) begin
                r_phase  <= PH_COUNT;
                r_remain <= 8'd0;
                r_pad    <= 1'b0;
            end else if (i_mode == MODE_RLE8) begin
                r_phase  <= n_phase;
                r_remain <= n_remain;
                r_pad    <= n_pad;
            end
        end
    end

endmodule

### rtl/core/dpir_queue.sv
// Short queue between front and back ends.
module dpir_queue
    import dpir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_head_vld,
    output t_qent o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_qent         r_buf [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_buf[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/core/dpir_back.sv
// Back end: translation table, lookup stage and output register.
module dpir_back
    import dpir_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_vld,
    input  t_qent      i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_out,
    output logic       o_last_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [8:0] ENT_LIMIT = 9'(TABLE_ENTRIES);

    logic [7:0]    r_mem [TABLE_ENTRIES];
    logic [7:0]    r_rd_lo, r_rd_hi;

    logic          r_s1_vld;
    t_kind         r_s1_kind;
    logic [7:0]    r_s1_byte;
    logic          r_s1_last;
    logic          r_s1_rng;

    logic          r_out_vld;
    logic [7:0]    r_out_data;
    logic          r_out_last;

    logic          out_free, s1_go, s1_load, tbl_wr, wr_rng, rd_rng;
    logic [AW-1:0] rd_addr_lo, rd_addr_hi;
    logic [7:0]    n_out_data;

    assign out_free = !r_out_vld || i_out_ready;
    assign s1_go    = r_s1_vld && out_free;
    assign s1_load  = i_head_vld && (i_head.cmd == CMD_DATA) && (!r_s1_vld || s1_go);
    assign tbl_wr   = i_head_vld && (i_head.cmd == CMD_WRITE);
    assign o_pop    = tbl_wr || s1_load;

    assign wr_rng = ({1'b0, i_head.index} < ENT_LIMIT);
    assign rd_rng = ({1'b0, i_head.value} < ENT_LIMIT);

    // nibble mode looks up both halves; full mode the whole byte
    assign rd_addr_lo = (i_head.kind == KIND_NIBBLE) ?
                        AW'(i_head.value[3:0] & NIBBLE_MASK) : i_head.value[AW-1:0];
    assign rd_addr_hi = AW'(i_head.value[7:4] & NIBBLE_MASK);

    always_ff @(posedge i_clk) begin
        if (tbl_wr && wr_rng) begin
            r_mem[i_head.index[AW-1:0]] <= i_head.value;
        end
        if (s1_load) begin
            r_rd_lo <= r_mem[rd_addr_lo];
            r_rd_hi <= r_mem[rd_addr_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind <= i_head.kind;
            r_s1_byte <= i_head.value;
            r_s1_last <= i_head.last;
            r_s1_rng  <= rd_rng;
        end
    end

    // full: T[b], 0 out of range; nibble: (T[lo] | T[hi] << 4) & 0xff; pass: b
    always_comb begin
        case (r_s1_kind)
            KIND_FULL:   n_out_data = r_s1_rng ? r_rd_lo : 8'd0;
            KIND_NIBBLE: n_out_data = {r_rd_lo[7:4] | r_rd_hi[3:0], r_rd_lo[3:0]};
            default:     n_out_data = r_s1_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_data_out  = r_out_data;
    assign o_last_out  = r_out_last;

`ifndef SYNTHESIS
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_vld)
        else $error("lookup beat lost on way to output");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_out_ready) |=> r_s1_vld)
        else $error("lookup beat dropped while output stalled");

    a_one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tbl_wr && s1_load))
        else $error("table write and lookup popped together");
`endif

endmodule

### rtl/core/dib_palette_index_remap.sv
// Top level: palette index remap of a bitmap byte stream (8-bit, 4-bit, RLE8; RLE4 passes through).
// Throughput: one beat per cycle on both channels, table writes and data alike,
//   as long as i_out_ready does not stall the output register.
// Path: a data beat passes the queue, the table read and then the output register.
// Reset: synchronous, active low; clears pixel_mode, parser, queue and valids.
//   The translation table is not cleared and holds garbage until written.
module dib_palette_index_remap
    import dpir_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    // pixel_mode register
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,

    // input beats
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,

    // result beats
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_out,
    output logic       o_last_out
);

    t_mode r_pixel_mode;
    logic  in_accept;
    logic  q_full, q_head_vld, q_pop;
    t_qent front_ent, q_head;

    // user must change mode only while idle (block does not enforce it); front classifies at accept time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= MODE_8BIT;
        end else if (i_cfg_we) begin
            r_pixel_mode <= t_mode'(i_cfg_wdata);
        end
    end

    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    // front: RLE8 parser, tags which bytes need a table lookup
    dpir_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_pixel_mode),
        .i_accept      (in_accept),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .o_ent         (front_ent)
    );

    // decouples parser from table/output side
    dpir_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_accept),
        .i_ent      (front_ent),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_head_vld (q_head_vld),
        .o_head     (q_head)
    );

    // back: table writes, lookups, nibble repack, output register
    dpir_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_vld  (q_head_vld),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_last_out  (o_last_out)
    );

endmodule

### tb/dib_palette_index_remap_checker.sv
`timescale 1ns / 100ps
// Checker for the palette index remap block: watches both channels, predicts and compares.
module dib_palette_index_remap_checker
    import dpir_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_data_out,
    input  logic       i_last_out,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } remap_beat_t;

    logic [7:0]  xlat [TABLE_ENTRIES];
    t_mode       mode;
    t_phase      phase;
    logic [7:0]  lit_left;
    logic        pad_due;
    remap_beat_t remap_q[$];

    function automatic logic [7:0] xlat_read(input logic [7:0] idx);
        if (int'(idx) >= TABLE_ENTRIES)
            return 8'h00;
        return xlat[idx];
    endfunction

    // RLE8 parser: only run indices and absolute-run literals are translated
    function automatic logic [7:0] rle8_remap(input logic [7:0] b);
        logic [7:0] res;
        res = b;
        case (phase)
            PH_COUNT: begin
                if (b != 8'd0)
                    phase = PH_INDEX;
                else
                    phase = PH_ESC;
            end
            PH_INDEX: begin
                res   = xlat_read(b);
                phase = PH_COUNT;
            end
            PH_ESC: begin
                if (b == ESC_EOL) begin
                    phase = PH_COUNT;
                end else if (b == ESC_EOB) begin
                    phase = PH_DONE;
                end else if (b == ESC_DELTA) begin
                    phase = PH_DELTA_X;
                end else begin
                    lit_left = b;
                    pad_due  = b[0];
                    phase    = PH_LITERAL;
                end
            end
            PH_DELTA_X: phase = PH_DELTA_Y;
            PH_DELTA_Y: phase = PH_COUNT;
            PH_LITERAL: begin
                res = xlat_read(b);
                if (lit_left != 8'd0)
                    lit_left = lit_left - 8'd1;
                if (lit_left == 8'd0) begin
                    if (pad_due)
                        phase = PH_PAD;
                    else
                        phase = PH_COUNT;
                    pad_due = 1'b0;
                end
            end
            PH_PAD: phase = PH_COUNT;
            default: ;  // end of bitmap: hold until last_byte
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        remap_beat_t want;
        logic [7:0]  res;
        logic [7:0]  lo;
        logic [7:0]  hi;
        if (!i_rst_n) begin
            mode     = MODE_8BIT;
            phase    = PH_COUNT;
            lit_left = 8'd0;
            pad_due  = 1'b0;
            remap_q.delete();
        end else begin
            if (i_cfg_we)
                mode = t_mode'(i_cfg_wdata);

            if (i_out_valid && i_out_ready) begin
                if (remap_q.size() == 0) begin
                    $error("unexpected result beat: data_out %02h last_out %0b",
                           i_data_out, i_last_out);
                    o_fail_count++;
                end else begin
                    want = remap_q.pop_front();
                    if (i_data_out !== want.data) begin
                        $error("data_out mismatch: expected %02h, actual %02h",
                               want.data, i_data_out);
                        o_fail_count++;
                    end
                    if (i_last_out !== want.last) begin
                        $error("last_out mismatch: expected %0b, actual %0b",
                               want.last, i_last_out);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (t_cmd'(i_cmd) == CMD_WRITE) begin
                    if (int'(i_entry_index) < TABLE_ENTRIES)
                        xlat[i_entry_index] = i_byte_value;
                end else begin
                    case (mode)
                        MODE_8BIT: res = xlat_read(i_byte_value);
                        MODE_4BIT: begin
                            lo  = xlat_read({4'h0, i_byte_value[3:0] & NIBBLE_MASK});
                            hi  = xlat_read({4'h0, i_byte_value[7:4] & NIBBLE_MASK});
                            res = lo | {hi[3:0], 4'h0};
                        end
                        MODE_RLE8: res = rle8_remap(i_byte_value);
                        default:   res = i_byte_value;
                    endcase
                    if (i_last_byte) begin
                        phase    = PH_COUNT;
                        lit_left = 8'd0;
                        pad_due  = 1'b0;
                    end
                    remap_q.push_back('{res, i_last_byte});
                end
            end
        end
        o_pending = remap_q.size();
    end

endmodule

### tb/dib_palette_index_remap_tb.sv
`timescale 1ns / 100ps
// Testbench top for the palette index remap block: clock, reset, stimulus and verdict.
module dib_palette_index_remap_tb;
    import dpir_pkg::*;

    localparam int CLK_HALF     = 6;     // 12 ns period
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 6;     // covers queue + table read + output register
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either channel
    localparam int RANDOM_BEATS = 440;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_wdata   = 2'd0;
    logic       i_in_valid    = 1'b0;
    logic       i_cmd         = 1'b0;
    logic [7:0] i_entry_index = 8'd0;
    logic [7:0] i_byte_value  = 8'd0;
    logic       i_last_byte   = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_data_out;
    logic       o_last_out;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int quiet_count = 0;
    bit tx_calm     = 1'b0;  // sender runs back to back while set
    bit rx_calm     = 1'b0;  // sink never stalls while set

    always #(CLK_HALF) i_clk = ~i_clk;

    dib_palette_index_remap uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_last_out    (o_last_out)
    );

    dib_palette_index_remap_checker remap_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_data_out    (o_data_out),
        .i_last_out    (o_last_out),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Watchdog: any cycle that moves a beat on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
    end

    initial begin : watchdog
        wait (quiet_count >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Result sink: a random stall ahead of every beat, with calm stretches.
    initial begin : result_sink
        int stall;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // One input beat. Entered and left at a falling edge. With no gap, valid stays
    // high and only the payload moves, so valid is never dropped and raised in one step.
    task automatic send_beat(input t_cmd c, input logic [7:0] idx, input logic [7:0] val,
                             input logic lst);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= c;
        i_entry_index <= idx;
        i_byte_value  <= val;
        i_last_byte   <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Data beat; entry_index is don't-care here, so it gets noise.
    task automatic put_byte(input logic [7:0] val, input logic lst);
        send_beat(CMD_DATA, 8'($urandom), val, lst);
    endtask

    // Random-part data beat, now and then preceded by a table rewrite.
    task automatic stream_byte(input logic [7:0] val, input logic lst);
        if ($urandom_range(0, 11) == 0)
            send_beat(CMD_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
        put_byte(val, lst);
    endtask

    // Mode register is only touched with the pipe empty. Table writes give no
    // result, so after the last result a SETTLE wait lets them land.
    task automatic set_mode(input t_mode m);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One RLE8 image: mostly legal opcodes with random content, some noise,
    // and a mix of clean, trailing-garbage, truncated and open-ended endings.
    task automatic rle8_image();
        int n;
        repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin  // encoded run
                    stream_byte(8'($urandom_range(1, 255)), 1'b0);
                    stream_byte(8'($urandom), 1'b0);
                end
                4: begin
                    stream_byte(8'd0, 1'b0);
                    stream_byte(ESC_EOL, 1'b0);
                end
                5: begin
                    stream_byte(8'd0, 1'b0);
                    stream_byte(ESC_DELTA, 1'b0);
                    stream_byte(8'($urandom), 1'b0);
                    stream_byte(8'($urandom), 1'b0);
                end
                6, 7, 8: begin  // absolute run; long ones are rare
                    n = ($urandom_range(0, 29) == 0) ? $urandom_range(3, 255)
                                                     : $urandom_range(3, 14);
                    stream_byte(8'd0, 1'b0);
                    stream_byte(8'(n), 1'b0);
                    repeat (n) stream_byte(8'($urandom), 1'b0);
                    if (n % 2 == 1)
                        stream_byte(8'($urandom), 1'b0);  // pad
                end
                default: stream_byte(8'($urandom), 1'b0);
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                stream_byte(8'd0, 1'b0);
                stream_byte(ESC_EOB, 1'b1);
            end
            1: begin  // bytes after end of bitmap pass through until last
                stream_byte(8'd0, 1'b0);
                stream_byte(ESC_EOB, 1'b0);
                repeat ($urandom_range(1, 4)) stream_byte(8'($urandom), 1'b0);
                stream_byte(8'($urandom), 1'b1);
            end
            2: stream_byte(8'($urandom), 1'b1);  // cut short wherever the parser is
            default: ;                           // no end: next image starts mid-parse
        endcase
    endtask

    initial begin : stimulus
        int   phase_no;
        t_mode m;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Table is garbage after reset: load every entry before any lookup.
        // last_byte on the final write must be ignored.
        for (int e = 0; e < DEFAULT_TABLE_ENTRIES; e++)
            send_beat(CMD_WRITE, 8'(e), (e == 0) ? 8'hff : 8'($urandom),
                      e == DEFAULT_TABLE_ENTRIES - 1);

        // --- directed ---
        // 8-bit mode, extremes of the byte
        put_byte(8'h00, 1'b0);
        put_byte(8'hff, 1'b1);

        // 4-bit: each nibble at its extremes
        set_mode(MODE_4BIT);
        put_byte(8'h0f, 1'b0);
        put_byte(8'hf0, 1'b0);

        // RLE8: encoded run, end of line, delta, odd absolute run with pad
        set_mode(MODE_RLE8);
        put_byte(8'h03, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(ESC_EOL, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(ESC_DELTA, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h03, 1'b0);
        put_byte(8'h10, 1'b0);
        put_byte(8'hff, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h5a, 1'b0);  // pad

        // even absolute run, interrupted by a mode switch; parser must hold
        put_byte(8'h00, 1'b0);
        put_byte(8'h04, 1'b0);
        put_byte(8'h21, 1'b0);
        set_mode(MODE_8BIT);
        put_byte(8'h80, 1'b0);
        set_mode(MODE_RLE8);
        put_byte(8'h42, 1'b0);
        send_beat(CMD_WRITE, 8'h00, 8'hff, 1'b1);  // last on a write leaves parser alone
        put_byte(8'h63, 1'b0);

        // last literal of that run, then a run of count 1 (index 07); last resets the parser
        put_byte(8'h00, 1'b0);
        put_byte(ESC_EOB, 1'b0);
        put_byte(8'h07, 1'b0);
        put_byte(8'h00, 1'b1);

        set_mode(MODE_RLE4);
        put_byte(8'hab, 1'b1);

        // --- random phases: first one per mode in order, then biased to RLE8 ---
        phase_no = 0;
        while (beats_sent < DEFAULT_TABLE_ENTRIES + 30 + RANDOM_BEATS) begin
            if (phase_no < 4)
                m = t_mode'(phase_no);
            else if ($urandom_range(0, 1) == 1)
                m = MODE_RLE8;
            else
                m = t_mode'($urandom_range(0, 3));
            set_mode(m);
            tx_calm = ($urandom_range(0, 3) == 0);
            if (m == MODE_RLE8)
                repeat ($urandom_range(2, 5)) rle8_image();
            else
                repeat ($urandom_range(20, 60))
                    stream_byte(8'($urandom), $urandom_range(0, 15) == 0);
            phase_no++;
        end

        // drain: the watchdog catches anything left outstanding
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### dib_palette_index_remap.f
rtl/core/dpir_pkg.sv
rtl/core/dpir_front.sv
rtl/core/dpir_queue.sv
rtl/core/dpir_back.sv
rtl/core/dib_palette_index_remap.sv
tb/dib_palette_index_remap_checker.sv
tb/dib_palette_index_remap_tb.sv
